// ----- rtl/rotated_direction_from_angles_defines.svh -----
// Assertion macros for the rotated direction block.
// Used by the port checker; needs clk and arst_n in scope.
`ifndef ROTATED_DIRECTION_FROM_ANGLES_DEFINES_SVH
`define ROTATED_DIRECTION_FROM_ANGLES_DEFINES_SVH

// same-cycle implication
`define RDFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RDFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// implication after a fixed delay
`define RDFA_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ----- rtl/rdfa_pkg.sv -----
// Shared types, constants and CORDIC helpers for the rotated direction block.
// No dependencies.
`default_nettype none

package rdfa_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CSTEPS_USED  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int CNT_W        = $clog2(CSTEPS_USED);
	// accept edge to sampled result strobe
	localparam int PIPE_LAT     = CSTEPS_USED + 5;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Z_ANGLE = 2'd1;

	localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
	localparam logic signed [33:0] HALF_PI  = 34'sd843314857;
	localparam logic signed [33:0] PI_Q29   = 34'sd1686629713;
	localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
	localparam logic signed [16:0] UNIT_Q14 = 17'sd16384;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic               flip;
	} cordic_t;

	typedef logic signed [16:0] rot_entry_t;
	typedef logic [8:0][16:0]   rot_mat_t;

	// arctangent of 2^-i, Q2.29
	function automatic logic signed [33:0] atan_q29(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:    r = 34'sd421657428;
			5'd1:    r = 34'sd248918915;
			5'd2:    r = 34'sd131521918;
			5'd3:    r = 34'sd66762579;
			5'd4:    r = 34'sd33510843;
			5'd5:    r = 34'sd16771758;
			5'd6:    r = 34'sd8387925;
			5'd7:    r = 34'sd4194219;
			5'd8:    r = 34'sd2097141;
			5'd9:    r = 34'sd1048575;
			5'd10:   r = 34'sd524288;
			5'd11:   r = 34'sd262144;
			5'd12:   r = 34'sd131072;
			5'd13:   r = 34'sd65536;
			5'd14:   r = 34'sd32768;
			5'd15:   r = 34'sd16384;
			5'd16:   r = 34'sd8192;
			5'd17:   r = 34'sd4096;
			5'd18:   r = 34'sd2048;
			5'd19:   r = 34'sd1024;
			5'd20:   r = 34'sd512;
			5'd21:   r = 34'sd256;
			5'd22:   r = 34'sd128;
			5'd23:   r = 34'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

	// widen Q3.13 to Q2.29 and fold into [-pi/2, pi/2]
	function automatic cordic_t cordic_fold(input logic signed [15:0] a);
		cordic_t            c;
		logic signed [33:0] z;
		z      = {{2{a[15]}}, a, 16'b0};
		c.x    = GAIN_INV;
		c.y    = '0;
		c.flip = 1'b0;
		if (z > HALF_PI) begin
			c.z    = z - PI_Q29;
			c.flip = 1'b1;
		end else if (z < -HALF_PI) begin
			c.z    = z + PI_Q29;
			c.flip = 1'b1;
		end else begin
			c.z = z;
		end
		return c;
	endfunction

	// one rotation step
	function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] i);
		cordic_t            n;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		dx     = c.y >>> i;
		dy     = c.x >>> i;
		n.flip = c.flip;
		if (!c.z[33]) begin
			n.x = c.x - dx;
			n.y = c.y + dy;
			n.z = c.z - atan_q29(i);
		end else begin
			n.x = c.x + dx;
			n.y = c.y - dy;
			n.z = c.z + atan_q29(i);
		end
		return n;
	endfunction

	function automatic logic signed [31:0] cordic_sin(input cordic_t c);
		logic signed [33:0] t;
		t = c.flip ? -c.y : c.y;
		return t[31:0];
	endfunction

	function automatic logic signed [31:0] cordic_cos(input cordic_t c);
		logic signed [33:0] t;
		t = c.flip ? -c.x : c.x;
		return t[31:0];
	endfunction

	function automatic rot_entry_t sat_q14(input logic signed [63:0] v);
		rot_entry_t r;
		if (v > 64'sd16384) begin
			r = UNIT_Q14;
		end else if (v < -64'sd16384) begin
			r = -UNIT_Q14;
		end else begin
			r = v[16:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rdfa_cordic.sv -----
// Dual-lane pipelined CORDIC: sine and cosine of two angles, one pair per cycle.
// Depends on rdfa_pkg.
`default_nettype none

module rdfa_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  logic signed [15:0]  ang_a,
	input  logic signed [15:0]  ang_b,
	output logic                res_vld,
	output logic signed [31:0]  sin_a,
	output logic signed [31:0]  cos_a,
	output logic signed [31:0]  sin_b,
	output logic signed [31:0]  cos_b
);
	import rdfa_pkg::*;

	localparam int N = CSTEPS_USED;

	cordic_t    a_s [N+1];
	cordic_t    b_s [N+1];
	logic [N:0] v_s;

	// quadrant fold, then one register stage per rotation step
	always_ff @(posedge clk) begin
		a_s[0] <= cordic_fold(ang_a);
		b_s[0] <= cordic_fold(ang_b);
		for (int g = 0; g < N; g++) begin
			a_s[g+1] <= cordic_step(a_s[g], 5'(g));
			b_s[g+1] <= cordic_step(b_s[g], 5'(g));
		end
	end

	// undo the fold sign and register results
	always_ff @(posedge clk) begin
		sin_a <= cordic_sin(a_s[N]);
		cos_a <= cordic_cos(a_s[N]);
		sin_b <= cordic_sin(b_s[N]);
		cos_b <= cordic_cos(b_s[N]);
	end

	// valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s     <= '0;
			res_vld <= 1'b0;
		end else begin
			v_s     <= {v_s[N-1:0], vld};
			res_vld <= v_s[N];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rdfa_rot_build.sv -----
// Configuration registers and sequential rebuild of the rotation matrix.
// Depends on rdfa_pkg.
`default_nettype none

module rdfa_rot_build (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rdfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_data,
	output logic                              busy,
	output rdfa_pkg::rot_mat_t                rot
);
	import rdfa_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_ITER, ST_MUL, ST_DRAIN} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [3:0]         idx_q;
	logic [3:0]         prod_idx_q;
	logic               prod_v_q;
	logic signed [63:0] prod_q;
	logic [15:0]        ang_y_q;
	logic [15:0]        ang_z_q;
	cordic_t            ly_q;
	cordic_t            lz_q;
	rot_mat_t           rot_q;

	logic               cfg_go;
	logic [15:0]        new_y;
	logic [15:0]        new_z;
	logic signed [31:0] sy, cy, sz, cz;
	logic signed [31:0] op_a, op_b;

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign rot       = rot_q;
	assign cfg_go    = cfg_valid && cfg_ready &&
	                   ((cfg_index == REG_Y_ANGLE) || (cfg_index == REG_Z_ANGLE));
	assign new_y     = (cfg_index == REG_Y_ANGLE) ? cfg_data : ang_y_q;
	assign new_z     = (cfg_index == REG_Z_ANGLE) ? cfg_data : ang_z_q;

	assign sy = cordic_sin(ly_q);
	assign cy = cordic_cos(ly_q);
	assign sz = cordic_sin(lz_q);
	assign cz = cordic_cos(lz_q);

	// operand pair for matrix entry idx_q (row major)
	always_comb begin
		unique case (idx_q)
			4'd0: begin op_a = cz;      op_b = cy;      end
			4'd1: begin op_a = -sz;     op_b = Q30_ONE; end
			4'd2: begin op_a = cz;      op_b = sy;      end
			4'd3: begin op_a = sz;      op_b = cy;      end
			4'd4: begin op_a = cz;      op_b = Q30_ONE; end
			4'd5: begin op_a = sz;      op_b = sy;      end
			4'd6: begin op_a = Q30_ONE; op_b = -sy;     end
			4'd8: begin op_a = Q30_ONE; op_b = cy;      end
			default: begin op_a = '0;   op_b = '0;      end
		endcase
	end

	// CORDIC lanes and product register
	always_ff @(posedge clk) begin
		if (cfg_go) begin
			ly_q <= cordic_fold(new_y);
			lz_q <= cordic_fold(new_z);
		end else if (state_q == ST_ITER) begin
			ly_q <= cordic_step(ly_q, 5'(cnt_q));
			lz_q <= cordic_step(lz_q, 5'(cnt_q));
		end
		prod_q     <= op_a * op_b;
		prod_idx_q <= idx_q;
	end

	// sequencer, registers and matrix entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			prod_v_q <= 1'b0;
			ang_y_q  <= '0;
			ang_z_q  <= '0;
			rot_q    <= {UNIT_Q14, 17'sd0, 17'sd0, 17'sd0, UNIT_Q14,
			             17'sd0, 17'sd0, 17'sd0, UNIT_Q14};
		end else begin
			prod_v_q <= (state_q == ST_MUL);
			if (prod_v_q) begin
				rot_q[prod_idx_q] <= sat_q14((prod_q + (64'sd1 <<< 45)) >>> 46);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_go) begin
						ang_y_q <= new_y;
						ang_z_q <= new_z;
						cnt_q   <= '0;
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					if (cnt_q == CNT_W'(CSTEPS_USED - 1)) begin
						idx_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (idx_q == 4'd8) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rotated_direction_from_angles.sv -----
// Top level: direction from polar angles, rotated by a configured ZY matrix.
// Depends on rdfa_pkg, rdfa_cordic, rdfa_rot_build.
//
// Channel   Handshake                 Word
// input     start & !busy             theta, phi (Q3.13)
// result    result_valid (strobe)     dir_x, dir_y, dir_z (Q1.14)
// config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One item per cycle while busy is low; each result passes through the fold, one
// stage per CORDIC step, sign fix, two multiply stages, and sum and round.
// A register write rebuilds the matrix on one shared multiplier; busy is high
// and start is not taken while the rebuild runs.
// Reset loads the identity matrix and empties the pipeline. Results cannot be stalled.
`default_nettype none

module rotated_direction_from_angles (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [15:0]             theta,
	input  logic signed [15:0]             phi,
	output logic                           result_valid,
	output logic signed [15:0]             dir_x,
	output logic signed [15:0]             dir_y,
	output logic signed [15:0]             dir_z,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rdfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import rdfa_pkg::*;

	rot_mat_t           rot;
	logic               cor_vld;
	logic signed [31:0] st, ct, sp, cp;

	logic               v_s1;
	logic signed [63:0] p0_s1, p1_s1;
	logic signed [31:0] ct_s1;
	logic               v_s2;
	logic signed [48:0] m_s2 [3][3];
	logic signed [31:0] vec [3];
	logic signed [50:0] acc [3];
	rot_entry_t         res [3];

	rdfa_rot_build u_build (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.rot       (rot)
	);

	rdfa_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start && !busy),
		.ang_a   (theta),
		.ang_b   (phi),
		.res_vld (cor_vld),
		.sin_a   (st),
		.cos_a   (ct),
		.sin_b   (sp),
		.cos_b   (cp)
	);

	// stage 1: horizontal components
	always_ff @(posedge clk) begin
		p0_s1 <= st * cp;
		p1_s1 <= st * sp;
		ct_s1 <= ct;
	end

	assign vec[0] = 32'(p0_s1 >>> 30);
	assign vec[1] = 32'(p1_s1 >>> 30);
	assign vec[2] = ct_s1;

	// stage 2: vector times matrix, m_s2[j][k] = v[k] * R[k][j]
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				m_s2[j][k] <= vec[k] * rot_entry_t'(rot[k*3 + j]);
			end
		end
	end

	// column sums, round half up, saturate
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc[j] = 51'(m_s2[j][0]) + 51'(m_s2[j][1]) + 51'(m_s2[j][2]);
			res[j] = sat_q14(64'((acc[j] + (51'sd1 <<< 29)) >>> 30));
		end
	end

	always_ff @(posedge clk) begin
		dir_x <= res[0][15:0];
		dir_y <= res[1][15:0];
		dir_z <= res[2][15:0];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s1         <= cor_vld;
			v_s2         <= v_s1;
			result_valid <= v_s2;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rdfa_checker.sv -----
// Port-level checker for the rotated direction block, bound to the top level.
// Depends on rdfa_pkg and rotated_direction_from_angles_defines.svh.
`default_nettype none

`include "rotated_direction_from_angles_defines.svh"

module rdfa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           result_valid,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [rdfa_pkg::CFG_IDX_W-1:0] cfg_index
);
	import rdfa_pkg::*;

	logic cfg_known;
	assign cfg_known = (cfg_index == REG_Y_ANGLE) || (cfg_index == REG_Z_ANGLE);

	// no register write while the matrix is rebuilt
	`RDFA_ASSERT_IMP(a_busy_blocks_cfg, busy, !cfg_ready, "cfg_ready high while busy")
	// a known register write starts a rebuild
	`RDFA_ASSERT_NXT(a_cfg_rebuild, cfg_valid && cfg_ready && cfg_known, busy, "no rebuild")
	// an unknown register write is dropped
	`RDFA_ASSERT_NXT(a_cfg_ignored, cfg_valid && cfg_ready && !cfg_known, !busy, "bad rebuild")
	// every accepted word gives a result after the fixed latency
	`RDFA_ASSERT_DLY(a_latency, start && !busy, PIPE_LAT, result_valid, "result missing")

endmodule

bind rotated_direction_from_angles rdfa_checker u_rdfa_checker (.*);

`default_nettype wire

// ----- tb/tb_rotated_direction_from_angles.sv -----
// Self-checking bench for rotated_direction_from_angles: random and directed angle pairs,
// predicted by an in-bench CORDIC and ZY rotation model.
// Depends on rdfa_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_rotated_direction_from_angles;
	import rdfa_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RAND_ITEMS     = 1525;
	localparam int N_PHASES       = 8;
	localparam int STEPS_RUN      = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam longint GAIN0      = 64'sd652032874;
	localparam longint HPI_Q29    = 64'sd843314857;
	localparam longint PI_29      = 64'sd1686629713;
	localparam longint ONE_Q30    = 64'sd1073741824;
	localparam longint ATAN_TBL [24] = '{
		421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
		8387925, 4194219, 2097141, 1048575, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096,
		2048, 1024, 512, 256, 128, 64};

	typedef struct {
		logic signed [15:0] th;
		logic signed [15:0] ph;
	} angle_word_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} dir_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic signed [15:0]   theta = '0;
	logic signed [15:0]   phi = '0;
	logic                 result_valid;
	logic signed [15:0]   dir_x;
	logic signed [15:0]   dir_y;
	logic signed [15:0]   dir_z;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	angle_word_t pending_angles[$];
	dir_word_t   expected_dirs[$];
	int          n_queued = 0;
	int          n_taken = 0;
	int          n_cfg_done = 0;
	int          n_errors = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 22;
	logic        took = 1'b0;

	// predictor state: angles and Q1.14 matrix, row major
	logic signed [15:0] model_y_ang = '0;
	logic signed [15:0] model_z_ang = '0;
	longint             rot_q14 [9] = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};

	rotated_direction_from_angles dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_unit(input longint v);
		if (v > 16384)
			return 16384;
		if (v < -16384)
			return -16384;
		return v;
	endfunction

	// CORDIC sine and cosine, Q2.30, with quadrant fold
	task automatic sin_cos_q30(input logic signed [15:0] ang, output longint s,
			output longint c);
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		bit     flip;
		z = longint'(ang) * 65536;
		x = GAIN0;
		y = 0;
		flip = 0;
		if (z > HPI_Q29) begin
			z -= PI_29;
			flip = 1;
		end else if (z < -HPI_Q29) begin
			z += PI_29;
			flip = 1;
		end
		for (int i = 0; i < STEPS_RUN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_TBL[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_TBL[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	task automatic rebuild_rotation();
		longint sy, cy, sz, cz, acc;
		longint ym [3][3];
		longint zm [3][3];
		sin_cos_q30(model_y_ang, sy, cy);
		sin_cos_q30(model_z_ang, sz, cz);
		ym = '{'{cy, 0, -sy}, '{0, ONE_Q30, 0}, '{sy, 0, cy}};
		zm = '{'{cz, sz, 0}, '{-sz, cz, 0}, '{0, 0, ONE_Q30}};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += zm[k][i] * ym[j][k];
				rot_q14[i*3+j] = clamp_unit((acc + (64'sd1 <<< 45)) >>> 46);
			end
	endtask

	task automatic predict_direction(input angle_word_t a, output dir_word_t d);
		longint st, ct, sp, cp, acc;
		longint v [3];
		longint u [3];
		sin_cos_q30(a.th, st, ct);
		sin_cos_q30(a.ph, sp, cp);
		v[0] = (st * cp) >>> 30;
		v[1] = (st * sp) >>> 30;
		v[2] = ct;
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += v[k] * rot_q14[k*3+j];
			u[j] = clamp_unit((acc + (64'sd1 <<< 29)) >>> 30);
		end
		d.x = u[0][15:0];
		d.y = u[1][15:0];
		d.z = u[2][15:0];
	endtask

	// driver: next word goes out on the falling edge once the last one was taken
	always @(negedge clk) begin
		angle_word_t w;
		if (arst_n && (!start || took)) begin
			if (pending_angles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				w = pending_angles.pop_front();
				start <= 1'b1;
				theta <= w.th;
				phi   <= w.ph;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: accepts, config writes, result check, watchdog
	always @(posedge clk) begin
		angle_word_t a;
		dir_word_t   d;
		dir_word_t   e;
		bit          activity;
		activity = 0;
		if (arst_n) begin
			took <= start && !busy;
			if (start && !busy) begin
				a.th = theta;
				a.ph = phi;
				predict_direction(a, d);
				expected_dirs.push_back(d);
				n_taken <= n_taken + 1;
				activity = 1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_Y_ANGLE) begin
					model_y_ang = cfg_data;
					rebuild_rotation();
				end else if (cfg_index == REG_Z_ANGLE) begin
					model_z_ang = cfg_data;
					rebuild_rotation();
				end
				n_cfg_done <= n_cfg_done + 1;
				activity = 1;
			end
			if (result_valid) begin
				activity = 1;
				if (expected_dirs.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result word: %0d %0d %0d", dir_x, dir_y, dir_z);
				end else begin
					e = expected_dirs.pop_front();
					if (dir_x !== e.x || dir_y !== e.y || dir_z !== e.z) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
								e.x, e.y, e.z, dir_x, dir_y, dir_z);
					end
				end
			end
			quiet_cycles <= activity ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic queue_angles(input logic signed [15:0] th, input logic signed [15:0] ph);
		angle_word_t w;
		w.th = th;
		w.ph = ph;
		pending_angles.push_back(w);
		n_queued++;
	endtask

	// hold off until every word has been taken and answered
	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_taken != n_queued || expected_dirs.size() != 0 || start);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		int done_before;
		done_before = n_cfg_done;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(negedge clk);
		while (n_cfg_done == done_before);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic signed [15:0] edge_angles [12];
		int                 per_phase;
		logic [15:0]        ycfg [N_PHASES];
		logic [15:0]        zcfg [N_PHASES];
		edge_angles = '{0, 1, -1, 32767, -32768, 12867, 12868, -12867, -12868,
			25736, -25736, 6434};
		ycfg = '{16'h0000, 16'h7FFF, 16'h8000, 16'h3244, 16'h0000, 16'hCDBC, 16'h0000, 16'h0000};
		zcfg = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h6488, 16'h1922, 16'h0000, 16'h0000};
		ycfg[6] = 16'($urandom);
		zcfg[6] = 16'($urandom);
		ycfg[7] = 16'($urandom);
		zcfg[7] = 16'($urandom);
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: identity matrix after reset, fold boundaries and extremes
		for (int i = 0; i < 12; i++)
			queue_angles(edge_angles[i], edge_angles[(i * 5 + 3) % 12]);
		for (int i = 0; i < 12; i++)
			queue_angles(edge_angles[(i * 7 + 1) % 12], edge_angles[i]);
		wait_drained();

		// unmapped register indexes must leave the matrix alone
		write_reg(2'd2, 16'hFFFF);
		write_reg(2'd3, 16'h5A5A);
		queue_angles(16'sd4000, 16'sd2000);

		per_phase = RAND_ITEMS / N_PHASES;
		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			write_reg(REG_Y_ANGLE, ycfg[p]);
			write_reg(REG_Z_ANGLE, zcfg[p]);
			if (p < 3)
				send_idle_pct = 22;
			else if (p < 6)
				send_idle_pct = 62;
			else
				send_idle_pct = 0;
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(9) == 0)
					queue_angles(edge_angles[$urandom_range(11)], 16'($urandom));
				else
					queue_angles(16'($urandom), 16'($urandom));
			end
		end

		wait_drained();
		if (n_errors == 0 && expected_dirs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
